// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the transcoder RTL.
// Needs a clk and an active-low rst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only out of reset
`define ASSERT_ON(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked on every rising edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- hdl/ut_pkg.sv -----
// Shared types and constants of the UTF-8 to UTF-16 transcoder.
// No dependencies.
package ut_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_string;
  } in_beat_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        run_last;
  } out_beat_t;

  // a run of 1..4 bytes whose end is known, ready to decode
  typedef struct packed {
    logic [3:0][7:0] run_bytes;
    logic [2:0]      len;
  } run_t;

  localparam logic [15:0] REPL_CHAR = 16'hFFFD;
  localparam logic [15:0] SUR_HI    = 16'hD800;
  localparam logic [15:0] SUR_LO    = 16'hDC00;
  localparam logic [20:0] CP_BASE   = 21'h10000;
  localparam logic [20:0] BMP_MAX   = 21'h00FFFF;

endpackage

// ----- hdl/ut_gather.sv -----
// Input side: holds the bytes of a pending sequence and registers each run once it completes or the string ends.
// Depends on ut_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ut_gather import ut_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_beat_t in_beat,
  input  logic     take,
  output logic     run_v,
  output run_t     run
);

  logic [7:0] held_r [3];
  logic [1:0] hcnt_r, hcnt_nxt;
  logic [2:0] need_r, need_nxt;
  logic       run_v_r, run_v_nxt;
  run_t       run_r;

  logic [2:0]      cnt;
  logic [2:0]      need;
  logic            hold;
  logic            in_acc;
  logic [3:0][7:0] gbuf;

  function automatic logic [2:0] seq_len(input logic [7:0] c);
    logic [2:0] n;
    n = 3'd1;
    if (c[7:5] == 3'b110) n = 3'd2;
    else if (c[7:4] == 4'b1110) n = 3'd3;
    else if (c[7:3] == 5'b11110) n = 3'd4;
    return n;
  endfunction

  assign in_stall = run_v_r && !take;
  assign in_acc   = in_valid && !in_stall;
  assign run_v    = run_v_r;
  assign run      = run_r;

  always_comb begin
    cnt     = {1'b0, hcnt_r} + 3'd1;
    gbuf[0] = (hcnt_r == 2'd0) ? in_beat.data_byte : held_r[0];
    gbuf[1] = (hcnt_r == 2'd1) ? in_beat.data_byte : held_r[1];
    gbuf[2] = (hcnt_r == 2'd2) ? in_beat.data_byte : held_r[2];
    gbuf[3] = in_beat.data_byte;
    need    = (hcnt_r == 2'd0) ? seq_len(in_beat.data_byte) : need_r;
    hold    = !in_beat.end_of_string && (cnt < need);

    hcnt_nxt  = hcnt_r;
    need_nxt  = need_r;
    run_v_nxt = run_v_r && !take;
    if (in_acc) begin
      if (hold) begin
        hcnt_nxt = cnt[1:0];
        need_nxt = need;
      end else begin
        hcnt_nxt  = 2'd0;
        need_nxt  = 3'd0;
        run_v_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hcnt_r  <= 2'd0;
      need_r  <= 3'd0;
      run_v_r <= 1'b0;
    end else begin
      hcnt_r  <= hcnt_nxt;
      need_r  <= need_nxt;
      run_v_r <= run_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && hold) begin
      held_r[hcnt_r] <= in_beat.data_byte;
    end
    if (in_acc && !hold) begin
      run_r.run_bytes <= gbuf;
      run_r.len       <= cnt;
    end
  end

  `ASSERT_ON(a_need_above_held, (hcnt_r != 2'd0) |-> (need_r > {1'b0, hcnt_r}), "held count not below sequence length")
  `ASSERT_ON(a_need_range, (hcnt_r != 2'd0) |-> (need_r <= 3'd4), "sequence length out of range")
  `ASSERT_ON(a_fire_loads_run, (in_acc && !hold) |=> (run_v_r && run_r.len != 3'd0), "completed run not registered")

endmodule

// ----- hdl/ut_units.sv -----
// Output side: decodes a run into up to three UTF-16 units and sends them one a beat.
// Depends on ut_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ut_units import ut_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      run_v,
  input  run_t      run,
  output logic      take,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_beat
);

  typedef struct packed {
    logic [2:0][15:0] units;
    logic [1:0]       count;
  } dec_t;

  logic             res_v_r, res_v_nxt;
  logic [1:0]       idx_r, idx_nxt;
  logic [1:0]       cnt_r;
  logic [2:0][15:0] units_r;
  dec_t             dec;
  logic             out_acc;
  logic             is_last;
  logic             res_done;
  logic             load;

  function automatic dec_t decode_run(input logic [3:0][7:0] rb, input logic [2:0] len);
    dec_t        d;
    logic [2:0]  pos, p1, p2, p3, rem, adv;
    logic [7:0]  c, b1, b2, b3;
    logic [20:0] cp, v;
    logic [1:0]  n;
    d   = '0;
    pos = 3'd0;
    n   = 2'd0;
    for (int k = 0; k < 4; k++) begin
      if (pos < len) begin
        p1  = pos + 3'd1;
        p2  = pos + 3'd2;
        p3  = pos + 3'd3;
        c   = rb[pos[1:0]];
        b1  = rb[p1[1:0]];
        b2  = rb[p2[1:0]];
        b3  = rb[p3[1:0]];
        rem = len - p1;
        if (!c[7]) begin
          cp  = {13'd0, c};
          adv = 3'd1;
        end else if (c[7:5] == 3'b110 && rem >= 3'd1) begin
          cp  = {10'd0, c[4:0], b1[5:0]};
          adv = 3'd2;
        end else if (c[7:4] == 4'b1110 && rem >= 3'd2) begin
          cp  = {5'd0, c[3:0], b1[5:0], b2[5:0]};
          adv = 3'd3;
        end else if (c[7:3] == 5'b11110 && rem >= 3'd3) begin
          cp  = {c[2:0], b1[5:0], b2[5:0], b3[5:0]};
          adv = 3'd4;
        end else begin
          cp  = {5'd0, REPL_CHAR};
          adv = 3'd1;
        end
        v = cp - CP_BASE;
        if (cp <= BMP_MAX) begin
          if (n != 2'd3) begin
            d.units[n] = cp[15:0];
            n = n + 2'd1;
          end
        end else begin
          if (n != 2'd3) begin
            d.units[n] = SUR_HI | {6'd0, v[19:10]};
            n = n + 2'd1;
          end
          if (n != 2'd3) begin
            d.units[n] = SUR_LO | {6'd0, v[9:0]};
            n = n + 2'd1;
          end
        end
        pos = pos + adv;
      end
    end
    d.count = n;
    return d;
  endfunction

  assign dec       = decode_run(run.run_bytes, run.len);
  assign out_valid = res_v_r;
  assign is_last   = (idx_r == cnt_r - 2'd1);
  assign out_acc   = res_v_r && !out_stall;
  assign res_done  = out_acc && is_last;
  assign take      = !res_v_r || res_done;
  assign load      = run_v && take;

  assign out_beat.code_unit = units_r[idx_r];
  assign out_beat.run_last  = is_last;

  always_comb begin
    res_v_nxt = res_v_r;
    idx_nxt   = idx_r;
    if (load) begin
      res_v_nxt = 1'b1;
      idx_nxt   = 2'd0;
    end else if (res_done) begin
      res_v_nxt = 1'b0;
    end else if (out_acc) begin
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_v_r <= 1'b0;
      idx_r   <= 2'd0;
    end else begin
      res_v_r <= res_v_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      units_r <= dec.units;
      cnt_r   <= dec.count;
    end
  end

  `ASSERT_ON(a_count_nonzero, res_v_r |-> (cnt_r != 2'd0), "result with no code units")
  `ASSERT_ON(a_idx_in_range, res_v_r |-> (idx_r < cnt_r), "unit index past count")
  `ASSERT_ON(a_load_starts, load |=> (res_v_r && idx_r == 2'd0), "run not loaded into result")

endmodule

// ----- hdl/utf8_to_utf16_decoder.sv -----
// UTF-8 to UTF-16 transcoder, top level.
// Depends on ut_pkg, ut_gather and ut_units.
//
// Takes one UTF-8 byte per beat, flagged on the last byte of a string, and
// gives UTF-16 code units one per beat, run_last marking the final unit caused
// by a byte. A byte is accepted every cycle unless in_stall is high; lead and
// continuation bytes of a pending sequence are only held, and the byte that
// completes the sequence (or ends the string) registers the run, which is then
// decoded into the result register. A run gives one to three units (a
// surrogate pair, or replacement units for a cut-off sequence); they leave the
// single result register one a cycle while out_stall is low, and a registered
// run holds the input until the result register takes it. Lead classes: 00-7F,
// C0-DF, E0-EF, F0-F7; other leads give FFFD, continuations are not checked.
module utf8_to_utf16_decoder import ut_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_beat,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_beat
);

  logic run_v;
  logic take;
  run_t run;

  ut_gather u_gather (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_beat  (in_beat),
    .take     (take),
    .run_v    (run_v),
    .run      (run)
  );

  ut_units u_units (
    .clk       (clk),
    .rst_n     (rst_n),
    .run_v     (run_v),
    .run       (run),
    .take      (take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

endmodule

// ----- dv/tb_utf8_to_utf16_decoder.sv -----
// Testbench for utf8_to_utf16_decoder: directed byte table, then random UTF-8 strings.
// Expected code units: typed table rows, else an in-bench model; needs ut_pkg and the RTL.
module tb_utf8_to_utf16_decoder;
  import ut_pkg::*;

  localparam int LIMIT = 200000;
  localparam int RAND_BEATS = 75;

  // directed row: byte, end flag, typed expectation (count and up to three units)
  typedef struct packed {
    logic [7:0]  data;
    logic        eos;
    logic        typed;
    logic [1:0]  n;
    logic [47:0] u;
  } row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_beat_t  in_beat;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_beat;

  logic [7:0] pend_bytes [3];
  logic [1:0] pend_cnt;
  logic [2:0] pend_need;

  out_beat_t units_due [$];
  out_beat_t due_beat;
  int        errors = 0;
  int        cycles = 0;
  int        stall_left = 0;
  bit        calm = 1'b0;

  row_t plan [25] = '{
    '{8'h00, 1'b0, 1'b1, 2'd1, {16'h0000, 32'h0}},
    '{8'h7F, 1'b1, 1'b1, 2'd1, {16'h007F, 32'h0}},
    '{8'hC0, 1'b0, 1'b1, 2'd0, 48'h0},
    '{8'h80, 1'b0, 1'b0, 2'd0, 48'h0},
    '{8'hDF, 1'b0, 1'b0, 2'd0, 48'h0},
    '{8'hBF, 1'b1, 1'b0, 2'd0, 48'h0},
    '{8'hED, 1'b0, 1'b0, 2'd0, 48'h0},
    '{8'hA0, 1'b0, 1'b0, 2'd0, 48'h0},
    '{8'h80, 1'b0, 1'b0, 2'd0, 48'h0},
    '{8'hF7, 1'b0, 1'b0, 2'd0, 48'h0},
    '{8'hBF, 1'b0, 1'b0, 2'd0, 48'h0},
    '{8'hBF, 1'b0, 1'b0, 2'd0, 48'h0},
    '{8'hBF, 1'b1, 1'b0, 2'd0, 48'h0},
    '{8'h80, 1'b0, 1'b1, 2'd1, {REPL_CHAR, 32'h0}},
    '{8'hFF, 1'b1, 1'b1, 2'd1, {REPL_CHAR, 32'h0}},
    '{8'hF8, 1'b0, 1'b1, 2'd1, {REPL_CHAR, 32'h0}},
    '{8'hE0, 1'b1, 1'b1, 2'd1, {REPL_CHAR, 32'h0}},
    '{8'hE1, 1'b0, 1'b0, 2'd0, 48'h0},
    '{8'hC3, 1'b1, 1'b0, 2'd0, 48'h0},
    '{8'hF0, 1'b0, 1'b1, 2'd0, 48'h0},
    '{8'hF0, 1'b0, 1'b1, 2'd0, 48'h0},
    '{8'hF0, 1'b1, 1'b1, 2'd3, {REPL_CHAR, REPL_CHAR, REPL_CHAR}},
    '{8'hF0, 1'b0, 1'b0, 2'd0, 48'h0},
    '{8'hC3, 1'b0, 1'b0, 2'd0, 48'h0},
    '{8'hA9, 1'b1, 1'b0, 2'd0, 48'h0}
  };

  utf8_to_utf16_decoder uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_beat  (in_beat),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_beat (out_beat)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // advances the held-sequence state by one byte; returns the code units it releases
  function automatic void transcode_byte(input in_beat_t b, output out_beat_t units[$]);
    logic [7:0]  span [4];
    logic [7:0]  c;
    logic [20:0] cp;
    logic [15:0] part [2];
    int          cnt;
    int          need;
    int          i;
    int          rem;
    int          nparts;
    int          k;
    units = {};
    for (i = 0; i < 4; i++) begin
      span[i] = (i < pend_cnt) ? pend_bytes[i] : 8'h00;
    end
    span[pend_cnt] = b.data_byte;
    cnt = pend_cnt + 1;
    if (!b.end_of_string) begin
      if (pend_cnt != 0) need = pend_need;
      else if (b.data_byte[7:5] == 3'b110) need = 2;
      else if (b.data_byte[7:4] == 4'hE) need = 3;
      else if (b.data_byte[7:3] == 5'h1E) need = 4;
      else need = 1;
      if (cnt < need) begin
        pend_bytes[cnt-1] = b.data_byte;
        pend_cnt = 2'(cnt);
        pend_need = 3'(need);
        return;
      end
    end
    i = 0;
    while (i < cnt) begin
      c = span[i];
      i++;
      rem = cnt - i;
      if (c < 8'h80) begin
        cp = {13'd0, c};
      end else if (c[7:5] == 3'b110 && rem >= 1) begin
        cp = {10'd0, c[4:0], span[i][5:0]};
        i += 1;
      end else if (c[7:4] == 4'hE && rem >= 2) begin
        cp = {5'd0, c[3:0], span[i][5:0], span[i+1][5:0]};
        i += 2;
      end else if (c[7:3] == 5'h1E && rem >= 3) begin
        cp = {c[2:0], span[i][5:0], span[i+1][5:0], span[i+2][5:0]};
        i += 3;
      end else begin
        cp = {5'd0, REPL_CHAR};
      end
      if (cp <= BMP_MAX) begin
        part[0] = cp[15:0];
        nparts = 1;
      end else begin
        cp = cp - CP_BASE;
        part[0] = SUR_HI + {6'd0, cp[19:10]};
        part[1] = SUR_LO + {6'd0, cp[9:0]};
        nparts = 2;
      end
      for (k = 0; k < nparts; k++) begin
        if (units.size() < 3) begin
          units.insert(units.size(), '{code_unit: part[k], run_last: 1'b0});
        end
      end
    end
    if (units.size() > 0) units[units.size()-1].run_last = 1'b1;
    pend_bytes = '{8'h00, 8'h00, 8'h00};
    pend_cnt = 2'd0;
    pend_need = 3'd0;
  endfunction

  // called just after a falling edge; returns just after the falling edge following acceptance
  task automatic send_beat(input logic [7:0] data, input logic eos, input logic typed,
                           input int n, input logic [47:0] u);
    in_beat_t  b;
    out_beat_t got [$];
    int        k;
    b = '{data_byte: data, end_of_string: eos};
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    transcode_byte(b, got);
    if (typed) begin
      got = {};
      for (k = 0; k < n; k++) begin
        got.insert(got.size(), '{code_unit: u[47-16*k -: 16], run_last: (k == n - 1)});
      end
    end
    foreach (got[k]) units_due.insert(units_due.size(), got[k]);
    @(negedge clk);
  endtask

  initial begin : stimulus
    in_beat_t seq [$];
    int       sent;
    int       kind;
    int       len;
    int       k;
    bit       cut;
    in_valid = 1'b0;
    in_beat  = '0;
    rst_n    = 1'b0;
    pend_bytes = '{8'h00, 8'h00, 8'h00};
    pend_cnt  = 2'd0;
    pend_need = 3'd0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[r]) begin
      send_beat(plan[r].data, plan[r].eos, plan[r].typed, plan[r].n, plan[r].u);
    end

    sent = 0;
    while (sent < RAND_BEATS) begin
      seq = {};
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1: begin
          seq.insert(seq.size(), '{data_byte: 8'($urandom_range(0, 127)), end_of_string: 1'b0});
        end
        2, 3: begin
          seq.insert(seq.size(),
                     '{data_byte: 8'($urandom_range(8'hC0, 8'hDF)), end_of_string: 1'b0});
        end
        4, 5: begin
          seq.insert(seq.size(),
                     '{data_byte: 8'($urandom_range(8'hE0, 8'hEF)), end_of_string: 1'b0});
        end
        6, 7: begin
          seq.insert(seq.size(),
                     '{data_byte: 8'($urandom_range(8'hF0, 8'hF7)), end_of_string: 1'b0});
        end
        8: begin
          if ($urandom_range(0, 1) == 0) begin
            seq.insert(seq.size(),
                       '{data_byte: 8'($urandom_range(8'h80, 8'hBF)), end_of_string: 1'b0});
          end else begin
            seq.insert(seq.size(),
                       '{data_byte: 8'($urandom_range(8'hF8, 8'hFF)), end_of_string: 1'b0});
          end
        end
        default: begin
          seq.insert(seq.size(), '{data_byte: 8'($urandom_range(0, 255)), end_of_string: 1'b0});
        end
      endcase
      len = (kind >= 2 && kind <= 7) ? (kind / 2) + 1 : 1;
      cut = (len > 1) && ($urandom_range(0, 5) == 0);
      if (cut) len = $urandom_range(1, len - 1);
      for (k = 1; k < len; k++) begin
        if ($urandom_range(0, 7) == 0) begin
          seq.insert(seq.size(), '{data_byte: 8'($urandom_range(0, 255)), end_of_string: 1'b0});
        end else begin
          seq.insert(seq.size(),
                     '{data_byte: 8'($urandom_range(8'h80, 8'hBF)), end_of_string: 1'b0});
        end
      end
      seq[seq.size()-1].end_of_string = cut || ($urandom_range(0, 3) == 0);
      foreach (seq[k]) begin
        calm = (sent >= RAND_BEATS * 3 / 4);
        send_beat(seq[k].data_byte, seq[k].end_of_string, 1'b0, 0, 48'h0);
        sent++;
      end
    end

    in_valid <= 1'b0;
    while (units_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    @(negedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  always @(negedge clk) begin
    if (!rst_n || calm) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 14);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (units_due.size() == 0) begin
        $error("unexpected beat: code_unit %h run_last %b", out_beat.code_unit,
               out_beat.run_last);
        errors++;
      end else begin
        due_beat = units_due.pop_front();
        if (out_beat.code_unit !== due_beat.code_unit) begin
          $error("code_unit: expected %h, got %h", due_beat.code_unit, out_beat.code_unit);
          errors++;
        end
        if (out_beat.run_last !== due_beat.run_last) begin
          $error("run_last: expected %b, got %b", due_beat.run_last, out_beat.run_last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

endmodule
